// ----- rtl/core/fbbt_pkg.sv -----
package fbbt_pkg;

	// defaults
	localparam int TICKS_PER_QUARTER_DEF = 960;

	// beat divisor = rate * 60 s * 100 (tempo in hundredths of a BPM)
	localparam logic [12:0] DEN_SCALE = 13'd6000;

	// field widths
	localparam int FRAME_W  = 40;
	localparam int TEMPO_W  = 17;
	localparam int RATE_W   = 19;
	localparam int BPB_W    = 6;
	localparam int UNIT_W   = 7;
	localparam int BAR_W    = 32;
	localparam int BEAT_W   = 6;
	localparam int TICK_W   = 12;

	// internal widths
	localparam int NUM_W    = 56;  // frame * tempo
	localparam int DEN_W    = 32;  // rate * 6000
	localparam int DUNIT_W  = DEN_W + UNIT_W;
	localparam int WHOLE_W  = 44;  // whole beats, den >= 6000

	// register word addresses
	typedef enum logic [1:0] {
		REG_TEMPO = 2'd0,
		REG_RATE  = 2'd1,
		REG_BPB   = 2'd2,
		REG_UNIT  = 2'd3
	} reg_addr_t;

endpackage

// ----- rtl/core/fbbt_div_cell.sv -----
// One restoring division step: shift, trial subtract, one quotient bit.
module fbbt_div_cell #(
	parameter int DW = 8,
	parameter int NW = 8,
	parameter int SW = 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               in_valid,
	input  logic [DW+NW-1:0]   in_word,
	input  logic [SW-1:0]      in_side,
	input  logic [DW-1:0]      divisor,
	output logic               out_valid,
	output logic [DW+NW-1:0]   out_word,
	output logic [SW-1:0]      out_side
);

	logic [DW+NW:0]   sh;
	logic [DW:0]      diff;
	logic [DW+NW-1:0] nxt;

	// partial remainder lives in the top DW bits, quotient fills from the bottom
	always_comb begin
		sh   = {in_word, 1'b0};
		diff = sh[DW+NW:NW] - {1'b0, divisor};
		if (!diff[DW]) begin
			nxt = {diff[DW-1:0], sh[NW-1:1], 1'b1};
		end else begin
			nxt = sh[DW+NW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_word <= nxt;
			out_side <= in_side;
		end
	end

endmodule

// ----- rtl/core/fbbt_div_chain.sv -----
// Row of NW division cells, one quotient bit per cell per cycle while adv is high.
module fbbt_div_chain #(
	parameter int DW = 8,
	parameter int NW = 8,
	parameter int SW = 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               in_valid,
	input  logic [DW+NW-1:0]   in_word,
	input  logic [SW-1:0]      in_side,
	input  logic [DW-1:0]      divisor,
	output logic               out_valid,
	output logic [DW+NW-1:0]   out_word,
	output logic [SW-1:0]      out_side
);

	logic               v_q [NW+1];
	logic [DW+NW-1:0]   w_q [NW+1];
	logic [SW-1:0]      s_q [NW+1];

	assign v_q[0] = in_valid;
	assign w_q[0] = in_word;
	assign s_q[0] = in_side;

	for (genvar i = 0; i < NW; i++) begin : g_cell
		fbbt_div_cell #(.DW(DW), .NW(NW), .SW(SW)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.in_valid (v_q[i]),
			.in_word  (w_q[i]),
			.in_side  (s_q[i]),
			.divisor  (divisor),
			.out_valid(v_q[i+1]),
			.out_word (w_q[i+1]),
			.out_side (s_q[i+1])
		);
	end

	assign out_valid = v_q[NW];
	assign out_word  = w_q[NW];
	assign out_side  = s_q[NW];

endmodule

// ----- rtl/core/frame_to_bars_beats_ticks_core.sv -----
// Frame position to bar / beat / tick converter.
// Slave stream s_*: one 40-bit signed frame index per word. Master stream m_*:
// one result word per input word, in order: bar, beat (both one-based), tick.
// The APB port holds tempo (1/100 BPM), sample rate, beats per bar and beat
// unit; write it only while no words are in flight. Derived divisors are
// registered: den_q follows the rate register and dunit_q follows den_q.
// Throughput: one word per cycle while m_tready does not hold it. The three
// divider rows (56 beat bits, 44 bar bits, KW tick bits with
// KW = clog2(4*TICKS_PER_QUARTER+1), 12 at the default) are chains of one-bit
// cells, each one registered, plus a multiply stage ahead of the beat row and
// one ahead of the bar row.
// The whole pipeline moves as one: when m_tready is low and a result is
// waiting, every stage holds and s_tready drops; the output register is the
// last cell of the tick row.
// Reset empties the pipeline and loads tempo 120.00 BPM, 48000 Hz, 4/4.
module frame_to_bars_beats_ticks_core #(
	parameter int TICKS_PER_QUARTER = fbbt_pkg::TICKS_PER_QUARTER_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// stream in
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // [39:0] frame_position
	// stream out
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // [31:0] bar_number, [37:32] beat_in_bar,
	                               // [49:38] tick_in_beat, [55:50] zero
	// config
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	import fbbt_pkg::*;

	localparam int KMUL = 4 * TICKS_PER_QUARTER;
	localparam int KW   = $clog2(KMUL + 1);
	localparam int TW   = DEN_W + KW;          // rem * KMUL
	localparam int SIDE_W = BAR_W + BEAT_W;

	// config registers
	logic [TEMPO_W-1:0] tempo_q;
	logic [RATE_W-1:0]  rate_q;
	logic [BPB_W-1:0]   bpb_q;
	logic [UNIT_W-1:0]  unit_q;
	logic [DEN_W-1:0]   den_q;
	logic [DUNIT_W-1:0] dunit_q;
	logic               wr;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tempo_q <= TEMPO_W'(12000);
			rate_q  <= RATE_W'(48000);
			bpb_q   <= BPB_W'(4);
			unit_q  <= UNIT_W'(4);
		end else if (wr) begin
			unique case (reg_addr_t'(paddr[3:2]))
				REG_TEMPO: tempo_q <= pwdata[TEMPO_W-1:0];
				REG_RATE:  rate_q  <= pwdata[RATE_W-1:0];
				REG_BPB:   bpb_q   <= pwdata[BPB_W-1:0];
				REG_UNIT:  unit_q  <= pwdata[UNIT_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (reg_addr_t'(paddr[3:2]))
			REG_TEMPO: prdata = 32'(tempo_q);
			REG_RATE:  prdata = 32'(rate_q);
			REG_BPB:   prdata = 32'(bpb_q);
			REG_UNIT:  prdata = 32'(unit_q);
		endcase
	end

	logic [RATE_W-1:0] rate_eff;
	logic [UNIT_W-1:0] unit_eff;
	logic [BPB_W-1:0]  bpb_eff;

	// zero rate maps to a rate of one with a zero numerator
	assign rate_eff = (rate_q == '0) ? RATE_W'(1) : rate_q;
	assign unit_eff = (unit_q == '0) ? UNIT_W'(4) : unit_q;
	assign bpb_eff  = (bpb_q == '0) ? BPB_W'(4) : bpb_q;

	// derived divisors, one multiply per register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			den_q   <= DEN_W'(48000 * 6000);
			dunit_q <= DUNIT_W'(48000 * 6000 * 4);
		end else begin
			den_q   <= DEN_W'(rate_eff) * DEN_W'(DEN_SCALE);
			dunit_q <= DUNIT_W'(den_q) * DUNIT_W'(unit_eff);
		end
	end

	logic adv;
	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;

	// stage 1: clamp and multiply by tempo
	logic             v_s1;
	logic [NUM_W-1:0] num_s1;
	logic [FRAME_W-2:0] frame_c;

	assign frame_c = (s_tdata[FRAME_W-1] || rate_q == '0) ? '0 : s_tdata[FRAME_W-2:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			num_s1 <= NUM_W'(frame_c) * NUM_W'(tempo_q);
		end
	end

	// beat division: num / den
	logic                   v_b;
	logic [DEN_W+NUM_W-1:0] w_b;
	logic                   sd_b;

	fbbt_div_chain #(.DW(DEN_W), .NW(NUM_W), .SW(1)) u_beat (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (v_s1),
		.in_word  ({{DEN_W{1'b0}}, num_s1}),
		.in_side  (1'b0),
		.divisor  (den_q),
		.out_valid(v_b),
		.out_word (w_b),
		.out_side (sd_b)
	);

	// stage 2: scale remainder to ticks
	logic               v_s2;
	logic [TW-1:0]      t_s2;
	logic [WHOLE_W-1:0] whole_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_b;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			t_s2     <= (TW'(w_b[DEN_W+NUM_W-1:NUM_W]) * TW'(KMUL)) | TW'(sd_b);
			whole_s2 <= w_b[WHOLE_W-1:0];
		end
	end

	// bar division: whole / beats per bar
	logic                     v_r;
	logic [BPB_W+WHOLE_W-1:0] w_r;
	logic [TW-1:0]            t_r;

	fbbt_div_chain #(.DW(BPB_W), .NW(WHOLE_W), .SW(TW)) u_bar (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (v_s2),
		.in_word  ({{BPB_W{1'b0}}, whole_s2}),
		.in_side  (t_s2),
		.divisor  (bpb_eff),
		.out_valid(v_r),
		.out_word (w_r),
		.out_side (t_r)
	);

	logic [BAR_W-1:0]  bar_n;
	logic [BEAT_W-1:0] beat_n;

	assign bar_n  = w_r[BAR_W-1:0] + BAR_W'(1);
	assign beat_n = w_r[BPB_W+WHOLE_W-1:WHOLE_W] + BEAT_W'(1);

	// tick division: rem * 4 * tpq / (den * unit)
	logic                   v_t;
	logic [DUNIT_W+KW-1:0]  w_t;
	logic [SIDE_W-1:0]      s_t;

	fbbt_div_chain #(.DW(DUNIT_W), .NW(KW), .SW(SIDE_W)) u_tick (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (v_r),
		.in_word  ((DUNIT_W+KW)'(t_r)),
		.in_side  ({beat_n, bar_n}),
		.divisor  (dunit_q),
		.out_valid(v_t),
		.out_word (w_t),
		.out_side (s_t)
	);

	assign m_tvalid = v_t;
	assign m_tdata  = {6'b0, TICK_W'(w_t[KW-1:0]), s_t};

endmodule

// ----- verif/frame_to_bars_beats_ticks_core_tb.sv -----
`timescale 1ns / 1ps

module frame_to_bars_beats_ticks_core_tb;
	import fbbt_pkg::*;

	localparam int TPQ = TICKS_PER_QUARTER_DEF;
	// pipeline depth: stage registers plus the three divider rows
	localparam int LAT = 2 + 56 + 44 + 12;
	localparam int LIMIT = 400000;
	localparam int LONG_HOLD = 400;

	typedef struct packed {
		logic [BAR_W-1:0]  bar;
		logic [BEAT_W-1:0] beat;
		logic [TICK_W-1:0] tick;
	} bbt_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [55:0] m_tdata;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	frame_to_bars_beats_ticks_core dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// register shadow
	logic [TEMPO_W-1:0] tempo_q;
	logic [RATE_W-1:0]  rate_q;
	logic [BPB_W-1:0]   bpb_q;
	logic [UNIT_W-1:0]  unit_q;

	logic [39:0] frame_q[$];
	bbt_t        bbt_q[$];
	int          errors;
	int          cycles;
	logic        hold_req;
	logic        hold_ack;
	int          hold_cnt;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// musical position of one frame under the current registers
	function automatic bbt_t frame_to_bbt(logic [39:0] frame);
		longint unsigned f, num, den, whole, rem, tick, bpb, unit;
		bbt_t r;
		f = frame[39] ? 64'd0 : {24'd0, frame};
		bpb = (bpb_q == 0) ? 64'd4 : bpb_q;
		unit = (unit_q == 0) ? 64'd4 : unit_q;
		whole = 0;
		tick = 0;
		if (tempo_q != 0 && rate_q != 0) begin
			num = f * tempo_q;
			den = longint'(rate_q) * 6000;
			whole = num / den;
			rem = num % den;
			tick = (rem * (TPQ * 4)) / (den * unit);
		end
		r.bar = BAR_W'(whole / bpb + 1);
		r.beat = BEAT_W'(whole % bpb + 1);
		r.tick = TICK_W'(tick);
		return r;
	endfunction

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// sender: bursts with random gaps
	int burst_left;
	int gap_left;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			burst_left <= 0;
			gap_left <= 0;
		end else if (!s_tvalid || s_tready) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				s_tvalid <= 1'b0;
			end else if (frame_q.size() > 0) begin
				s_tvalid <= 1'b1;
				s_tdata <= frame_q.pop_front();
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 40);
					gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver: own stall pattern, plus a long hold on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			hold_ack <= 1'b0;
			hold_cnt <= 0;
		end else if (hold_req != hold_ack) begin
			hold_ack <= hold_req;
			hold_cnt <= LONG_HOLD;
			m_tready <= 1'b0;
		end else if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
			m_tready <= 1'b0;
		end else begin
			case ((cycles / 97) % 3)
				0: begin
					m_tready <= 1'b1;
				end
				1: begin
					m_tready <= 1'($urandom_range(0, 1));
				end
				default: begin
					m_tready <= ($urandom_range(0, 3) == 0);
				end
			endcase
		end
	end

	// monitor: predict on input words, check output words
	always @(posedge clk) begin
		bbt_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				bbt_q.push_back(frame_to_bbt(s_tdata));
			if (m_tvalid && m_tready) begin
				if (bbt_q.size() == 0) begin
					$display("unexpected result word at %0t", $realtime);
					errors++;
				end else begin
					want = bbt_q.pop_front();
					if (m_tdata[31:0] !== want.bar)
						report("bar_number", m_tdata[31:0], want.bar);
					if (m_tdata[37:32] !== want.beat)
						report("beat_in_bar", m_tdata[37:32], want.beat);
					if (m_tdata[49:38] !== want.tick)
						report("tick_in_beat", m_tdata[49:38], want.tick);
					if (m_tdata[55:50] !== 6'd0)
						report("pad bits", m_tdata[55:50], 0);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("frame_to_bars_beats_ticks_core_tb failed");
			$finish;
		end
	end

	task automatic reg_write(reg_addr_t idx, logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_TEMPO: tempo_q = val[TEMPO_W-1:0];
			REG_RATE:  rate_q = val[RATE_W-1:0];
			REG_BPB:   bpb_q = val[BPB_W-1:0];
			default:   unit_q = val[UNIT_W-1:0];
		endcase
	endtask

	task automatic set_meter(logic [31:0] t, logic [31:0] r, logic [31:0] b, logic [31:0] u);
		reg_write(REG_TEMPO, t);
		reg_write(REG_RATE, r);
		reg_write(REG_BPB, b);
		reg_write(REG_UNIT, u);
		// divisors settle after the write
		repeat (4) @(posedge clk);
	endtask

	task automatic drain();
		while (frame_q.size() > 0 || s_tvalid || bbt_q.size() > 0)
			@(posedge clk);
		repeat (LAT + 10) @(posedge clk);
	endtask

	function automatic logic [39:0] rand_frame();
		logic [39:0] f;
		case ($urandom_range(0, 9))
			0, 1, 2: f = 40'($urandom_range(0, 2000000));
			3, 4:    f = {8'd0, $urandom};
			5, 6, 7: f = 40'({$urandom, $urandom});
			8:       f = -40'($urandom_range(1, 100000));
			default: f = 40'($urandom_range(0, 200));
		endcase
		return f;
	endfunction

	task automatic random_phase(int n);
		for (int i = 0; i < n; i++)
			frame_q.push_back(rand_frame());
		drain();
	endtask

	initial begin
		errors = 0;
		cycles = 0;
		hold_req = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		tempo_q = 12000;
		rate_q = 48000;
		bpb_q = 4;
		unit_q = 4;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		repeat (LAT + 10) @(posedge clk);

		// reset meter: edges of the frame range, beat and bar boundaries
		frame_q.push_back(40'd0);
		frame_q.push_back(40'd1);
		frame_q.push_back(40'h7F_FFFF_FFFF);
		frame_q.push_back(40'h80_0000_0000);
		frame_q.push_back(40'hFF_FFFF_FFFF);
		frame_q.push_back(40'd23999);
		frame_q.push_back(40'd24000);
		frame_q.push_back(40'd95999);
		frame_q.push_back(40'd96000);
		frame_q.push_back(40'd24001);
		frame_q.push_back(40'hAA_AAAA_AAAA);
		frame_q.push_back(40'h55_5555_5555);
		drain();

		// zero beats per bar and zero unit act as four
		set_meter(12000, 48000, 0, 0);
		frame_q.push_back(40'd96000);
		frame_q.push_back(40'd12345);
		// zero tempo
		drain();
		set_meter(0, 48000, 3, 8);
		frame_q.push_back(40'h7F_FFFF_FFFF);
		frame_q.push_back(40'd5000);
		drain();
		// zero rate
		set_meter(99999, 0, 7, 16);
		frame_q.push_back(40'h7F_FFFF_FFFF);
		frame_q.push_back(40'd77);
		drain();
		// fastest tempo, slowest rate: bar count wraps
		set_meter(131071, 1, 1, 1);
		frame_q.push_back(40'h7F_FFFF_FFFF);
		frame_q.push_back(40'd1);
		frame_q.push_back(40'd3);
		drain();

		// random content over several meters, extremes included
		set_meter(12000, 48000, 4, 4);
		random_phase(60);
		// long receiver hold while the sender keeps offering
		hold_req = 1'b1;
		random_phase(200);
		set_meter(1, 384000, 32, 64);
		random_phase(100);
		set_meter(99999, 1, 1, 1);
		random_phase(100);
		set_meter(131071, 524287, 63, 127);
		random_phase(100);
		set_meter(1, 1, 0, 0);
		random_phase(100);
		set_meter(524287 * 2 + 1, 44100, 6, 8);
		random_phase(100);
		hold_req = 1'b0;
		for (int p = 0; p < 5; p++) begin
			set_meter($urandom_range(1, 99999), $urandom_range(1, 384000),
				$urandom_range(0, 32), $urandom_range(0, 64));
			random_phase(110);
		end

		if (bbt_q.size() != 0) begin
			$display("%0d results never arrived", bbt_q.size());
			errors++;
		end
		if (errors == 0) begin
			$display("frame_to_bars_beats_ticks_core_tb passed");
		end else begin
			$display("frame_to_bars_beats_ticks_core_tb failed");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/core/fbbt_pkg.sv
rtl/core/fbbt_div_cell.sv
rtl/core/fbbt_div_chain.sv
rtl/core/frame_to_bars_beats_ticks_core.sv
verif/frame_to_bars_beats_ticks_core_tb.sv
